// File: hw/rtl/mvc_pkg.sv
`timescale 1ns / 1ps

package mvc_pkg;

  // Comparison modes held in the mode register.
  localparam logic [3:0] MODE_NONE      = 4'd0;
  localparam logic [3:0] MODE_EQ        = 4'd1;
  localparam logic [3:0] MODE_NE        = 4'd2;
  localparam logic [3:0] MODE_GT        = 4'd3;
  localparam logic [3:0] MODE_LT        = 4'd4;
  localparam logic [3:0] MODE_GE        = 4'd5;
  localparam logic [3:0] MODE_LE        = 4'd6;
  localparam logic [3:0] MODE_MOD_EQ    = 4'd7;
  localparam logic [3:0] MODE_MOD_GT    = 4'd8;
  localparam logic [3:0] MODE_MOD_LT    = 4'd9;
  localparam logic [3:0] MODE_FLOOR_EQ  = 4'd10;
  localparam logic [3:0] MODE_FLOOR_GT  = 4'd11;
  localparam logic [3:0] MODE_FLOOR_LT  = 4'd12;
  localparam logic [3:0] MODE_DIFF_GT   = 4'd13;
  localparam logic [3:0] MODE_DIFF_LT   = 4'd14;
  localparam logic [3:0] MODE_RANGE     = 4'd15;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_REF_A = 2'd1;
  localparam logic [1:0] CFG_REF_B = 2'd2;

  // Result of the iterative divider; the quotient carries one extra bit so
  // that the most negative dividend over minus one is still exact.
  typedef struct packed {
    logic               done;
    logic signed [32:0] quotient;
    logic signed [31:0] remainder;
  } div_res_t;

endpackage

// File: hw/rtl/mvc_divider.sv
`timescale 1ns / 1ps

module mvc_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  dividend_i,
  input  logic signed [31:0]  divisor_i,
  output mvc_pkg::div_res_t   res_o
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIX  = 2'd2;

  logic [1:0]         state_q;
  logic [4:0]         cnt_q;
  logic               done_q;
  logic [31:0]        quo_q;
  logic [31:0]        rem_q;
  logic [31:0]        den_q;
  logic               neg_quo_q;
  logic               neg_rem_q;
  logic signed [32:0] quo_res_q;
  logic signed [31:0] rem_res_q;

  logic [32:0]        shifted;
  logic [33:0]        trial;

  // One restoring step per cycle on the magnitudes.
  assign shifted = {rem_q, quo_q[31]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= 5'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            state_q <= D_RUN;
            cnt_q   <= 5'd0;
          end
        end
        D_RUN: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= D_FIX;
          end
        end
        D_FIX: begin
          state_q <= D_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          quo_q     <= dividend_i[31] ? (~dividend_i + 32'd1) : dividend_i;
          den_q     <= divisor_i[31] ? (~divisor_i + 32'd1) : divisor_i;
          rem_q     <= 32'd0;
          neg_quo_q <= dividend_i[31] ^ divisor_i[31];
          neg_rem_q <= dividend_i[31];
        end
      end
      D_RUN: begin
        if (!trial[33]) begin
          rem_q <= trial[31:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= shifted[31:0];
          quo_q <= {quo_q[30:0], 1'b0};
        end
      end
      D_FIX: begin
        // Quotient truncates toward zero, remainder takes the dividend's sign.
        quo_res_q <= neg_quo_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
        rem_res_q <= neg_rem_q ? -$signed(rem_q) : $signed(rem_q);
      end
      default: begin
      end
    endcase
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quo_res_q;
  assign res_o.remainder = rem_res_q;

endmodule

// File: hw/rtl/mvc_prev_store.sv
`timescale 1ns / 1ps

module mvc_prev_store #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [31:0]   rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [31:0]   wr_data_i,
  output logic          clear_busy_o
);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data_q;
  logic [AW-1:0] clr_cnt_q;
  logic          clr_busy_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  // After reset every entry is zeroed, one per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  assign mem_we    = clr_busy_q | wr_en_i;
  assign mem_waddr = clr_busy_q ? clr_cnt_q : wr_addr_i;
  assign mem_wdata = clr_busy_q ? 32'd0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o    = rd_data_q;
  assign clear_busy_o = clr_busy_q;

endmodule

// File: hw/rtl/multimode_value_comparator.sv
`timescale 1ns / 1ps

// Channel    Direction  Handshake                     Payload
// s_axis     in         s_axis_tvalid/s_axis_tready   tuser: channel, tdata: sample_value
// m_axis     out        m_axis_tvalid/m_axis_tready   tdata: match
// cfg        in         cfg_valid_i/cfg_ready_o       cfg_addr_i: index, cfg_data_i: value
//
// One word is worked on at a time. Remainder and quotient modes with a nonzero divisor
// pass through the 32-step radix-2 divider, its sign fix and hand-off, then the floor
// and compare states. Change modes pass through previous-value memory read, subtract,
// magnitude and compare; all other modes, and a zero divisor, go straight to compare.
// After reset the previous-value memory is zeroed entry by entry, with input held off.
// The result sits in an output register; a stalled output holds only the final compare.

module multimode_value_comparator #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_value
  input  logic [3:0]  s_axis_tuser,   // [3:0] channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] match, [7:1] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIFF  = 3'd1;
  localparam logic [2:0] ST_ABS   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FLOOR = 3'd4;
  localparam logic [2:0] ST_EVAL  = 3'd5;

  logic [3:0]         mode_q;
  logic signed [31:0] ref_a_q;
  logic signed [31:0] ref_b_q;

  logic [2:0]         state_q;
  logic [2:0]         state_d;
  logic               out_valid_q;
  logic               out_match_q;

  logic signed [31:0] x_q;
  logic [AW-1:0]      ch_idx_q;
  logic               ch_ok_q;
  logic signed [32:0] diff_q;
  logic [32:0]        absd_q;
  logic signed [31:0] qf_q;

  logic               in_accept;
  logic               is_div_mode;
  logic               is_diff_mode;
  logic               clear_busy;
  logic               out_free;
  logic               match;
  logic [AW+3:0]      ch_ext;
  logic [31:0]        prev_rd;
  logic signed [31:0] prev_val;
  logic signed [33:0] qfl;
  logic               floor_adj;
  logic               div_start;
  mvc_pkg::div_res_t  div_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= mvc_pkg::MODE_NONE;
      ref_a_q <= 32'sd0;
      ref_b_q <= 32'sd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        mvc_pkg::CFG_MODE:  mode_q  <= cfg_data_i[3:0];
        mvc_pkg::CFG_REF_A: ref_a_q <= cfg_data_i;
        mvc_pkg::CFG_REF_B: ref_b_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !clear_busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign is_div_mode  = (mode_q >= mvc_pkg::MODE_MOD_EQ) && (mode_q <= mvc_pkg::MODE_FLOOR_LT);
  assign is_diff_mode = (mode_q == mvc_pkg::MODE_DIFF_GT) || (mode_q == mvc_pkg::MODE_DIFF_LT);
  // A zero divisor skips the divider; the compare then reports false.
  assign div_start    = in_accept && is_div_mode && (ref_a_q != 32'sd0);

  assign ch_ext = (AW + 4)'(s_axis_tuser);

  mvc_prev_store #(
    .DEPTH (CHANNELS)
  ) u_prev_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (in_accept),
    .rd_addr_i    (ch_ext[AW-1:0]),
    .rd_data_o    (prev_rd),
    .wr_en_i      ((state_q == ST_DIFF) && ch_ok_q),
    .wr_addr_i    (ch_idx_q),
    .wr_data_i    (x_q),
    .clear_busy_o (clear_busy)
  );

  mvc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_axis_tdata),
    .divisor_i  (ref_a_q),
    .res_o      (div_res)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (div_start) begin
            state_d = ST_DIV;
          end else if (is_diff_mode) begin
            state_d = ST_DIFF;
          end else begin
            state_d = ST_EVAL;
          end
        end
      end
      ST_DIFF:  state_d = ST_ABS;
      ST_ABS:   state_d = ST_EVAL;
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_FLOOR;
        end
      end
      ST_FLOOR: state_d = ST_EVAL;
      ST_EVAL: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_EVAL) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // An out-of-range channel reads as zero and is never written back.
  assign prev_val = ch_ok_q ? $signed(prev_rd) : 32'sd0;

  // Floored quotient: step down when the division was inexact and the signs differ.
  assign floor_adj = (div_res.remainder != 32'sd0) && (x_q[31] != ref_a_q[31]);
  assign qfl       = 34'(div_res.quotient) - (floor_adj ? 34'sd1 : 34'sd0);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q      <= s_axis_tdata;
      ch_idx_q <= ch_ext[AW-1:0];
      ch_ok_q  <= (ch_ext < (AW + 4)'(CHANNELS));
    end
    if (state_q == ST_DIFF) begin
      diff_q <= 33'(x_q) - 33'(prev_val);
    end
    if (state_q == ST_ABS) begin
      absd_q <= diff_q[32] ? (~diff_q + 33'd1) : diff_q;
    end
    if (state_q == ST_FLOOR) begin
      if (qfl > 34'sd32767) begin
        qf_q <= 32'sh7fffffff;
      end else if (qfl < -34'sd32768) begin
        qf_q <= 32'sh80000000;
      end else begin
        qf_q <= {qfl[15:0], 16'd0};
      end
    end
    if ((state_q == ST_EVAL) && out_free) begin
      out_match_q <= match;
    end
  end

  always_comb begin
    unique case (mode_q)
      mvc_pkg::MODE_NONE:     match = 1'b1;
      mvc_pkg::MODE_EQ:       match = (x_q == ref_a_q);
      mvc_pkg::MODE_NE:       match = (x_q != ref_a_q);
      mvc_pkg::MODE_GT:       match = (x_q > ref_a_q);
      mvc_pkg::MODE_LT:       match = (x_q < ref_a_q);
      mvc_pkg::MODE_GE:       match = (x_q >= ref_a_q);
      mvc_pkg::MODE_LE:       match = (x_q <= ref_a_q);
      mvc_pkg::MODE_MOD_EQ:   match = (ref_a_q != 32'sd0) && (div_res.remainder == ref_b_q);
      mvc_pkg::MODE_MOD_GT:   match = (ref_a_q != 32'sd0) && (div_res.remainder > ref_b_q);
      mvc_pkg::MODE_MOD_LT:   match = (ref_a_q != 32'sd0) && (div_res.remainder < ref_b_q);
      mvc_pkg::MODE_FLOOR_EQ: match = (ref_a_q != 32'sd0) && (qf_q == ref_b_q);
      mvc_pkg::MODE_FLOOR_GT: match = (ref_a_q != 32'sd0) && (qf_q > ref_b_q);
      mvc_pkg::MODE_FLOOR_LT: match = (ref_a_q != 32'sd0) && (qf_q < ref_b_q);
      mvc_pkg::MODE_DIFF_GT:  match = ($signed({1'b0, absd_q}) > 34'(ref_a_q));
      mvc_pkg::MODE_DIFF_LT:  match = ($signed({1'b0, absd_q}) < 34'(ref_a_q));
      default:                match = (x_q >= ref_a_q) && (x_q <= ref_b_q);
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_match_q};

endmodule

// File: tb/multimode_value_comparator_tb.sv
`timescale 1ns / 1ps

module multimode_value_comparator_tb;

  localparam int unsigned CHANNELS = 16;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int ITEMS_PER_SETTING = 25;
  localparam int DRAIN_CYCLES = 48;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  class match_scoreboard;
    logic [3:0] mode;
    logic signed [31:0] ref_a;
    logic signed [31:0] ref_b;
    logic signed [31:0] prev_sample [CHANNELS];
    bit expected_match [$];
    int unsigned errors;

    function new();
      mode = mvc_pkg::MODE_NONE;
      ref_a = '0;
      ref_b = '0;
      errors = 0;
      foreach (prev_sample[i]) prev_sample[i] = '0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        mvc_pkg::CFG_MODE:  mode  = value[3:0];
        mvc_pkg::CFG_REF_A: ref_a = value;
        mvc_pkg::CFG_REF_B: ref_b = value;
        default: ;
      endcase
    endfunction

    function bit predict_match(logic [3:0] ch, logic signed [31:0] sample);
      longint x, a, b, r, q, d;
      bit m;
      x = sample;
      a = ref_a;
      b = ref_b;
      m = 1'b0;
      case (mode)
        mvc_pkg::MODE_NONE: m = 1'b1;
        mvc_pkg::MODE_EQ:   m = (x == a);
        mvc_pkg::MODE_NE:   m = (x != a);
        mvc_pkg::MODE_GT:   m = (x > a);
        mvc_pkg::MODE_LT:   m = (x < a);
        mvc_pkg::MODE_GE:   m = (x >= a);
        mvc_pkg::MODE_LE:   m = (x <= a);
        mvc_pkg::MODE_MOD_EQ, mvc_pkg::MODE_MOD_GT, mvc_pkg::MODE_MOD_LT: begin
          if (a != 0) begin
            r = x % a;
            m = (mode == mvc_pkg::MODE_MOD_EQ) ? (r == b) :
                (mode == mvc_pkg::MODE_MOD_GT) ? (r > b) : (r < b);
          end
        end
        mvc_pkg::MODE_FLOOR_EQ, mvc_pkg::MODE_FLOOR_GT, mvc_pkg::MODE_FLOOR_LT: begin
          if (a != 0) begin
            q = x / a;
            // Truncation rounds toward zero; step down when the signs differ.
            if ((x % a != 0) && ((x < 0) != (a < 0))) q = q - 1;
            if (q > 32767) q = Q_MAX;
            else if (q < -32768) q = Q_MIN;
            else q = q * 65536;
            m = (mode == mvc_pkg::MODE_FLOOR_EQ) ? (q == b) :
                (mode == mvc_pkg::MODE_FLOOR_GT) ? (q > b) : (q < b);
          end
        end
        mvc_pkg::MODE_DIFF_GT, mvc_pkg::MODE_DIFF_LT: begin
          d = x - longint'(prev_sample[ch]);
          if (d < 0) d = -d;
          m = (mode == mvc_pkg::MODE_DIFF_GT) ? (d > a) : (d < a);
          prev_sample[ch] = sample;
        end
        default: m = (x >= a) && (x <= b);
      endcase
      return m;
    endfunction

    function void note_sample(logic [3:0] ch, logic signed [31:0] sample);
      expected_match.push_back(predict_match(ch, sample));
    endfunction

    function void check_result(logic [7:0] word);
      bit want;
      if (expected_match.size() == 0) begin
        $error("match: no result expected, actual %0b", word[0]);
        errors++;
      end else begin
        want = expected_match.pop_front();
        if (word[0] !== want) begin
          $error("match: expected %0b, actual %0b", want, word[0]);
          errors++;
        end
        if (word[7:1] !== 7'd0) begin
          $error("tdata padding: expected 0x00, actual 0x%02h", word[7:1]);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i = mvc_pkg::CFG_MODE;
  logic [31:0] cfg_data_i = '0;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  match_scoreboard sb;

  multimode_value_comparator #(
    .CHANNELS(CHANNELS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (sb.expected_match.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [3:0] mode, logic [31:0] a, logic [31:0] b);
    s_axis_tvalid <= 1'b0;
    wait_idle();
    write_register(mvc_pkg::CFG_MODE, {28'd0, mode});
    write_register(mvc_pkg::CFG_REF_A, a);
    write_register(mvc_pkg::CFG_REF_B, b);
  endtask

  task automatic send_sample(logic [3:0] ch, logic [31:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ch;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(ch, value);
  endtask

  task automatic probe(logic [3:0] mode, logic [31:0] a, logic [31:0] b,
                       logic [3:0] ch, logic [31:0] value);
    apply_setting(mode, a, b);
    send_sample(ch, value);
  endtask

  // Q16.16 value between -8 and 8.75 in quarter steps.
  function automatic logic [31:0] small_q();
    int k;
    k = int'($urandom_range(16)) - 8;
    return 32'(k * 65536 + int'($urandom_range(3)) * 16384);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return small_q();
      default: return $urandom();
    endcase
  endfunction

  task automatic random_setting();
    logic [3:0] mode;
    logic signed [31:0] a, b;
    mode = 4'($urandom_range(15));
    a = pick_word();
    b = pick_word();
    if ($urandom_range(3) != 0) begin
      case (mode)
        mvc_pkg::MODE_MOD_EQ, mvc_pkg::MODE_MOD_GT, mvc_pkg::MODE_MOD_LT: begin
          a = small_q();
          b = a / (int'($urandom_range(3)) + 2);
          if ($urandom_range(1) != 0) b = -b;
        end
        mvc_pkg::MODE_FLOOR_EQ, mvc_pkg::MODE_FLOOR_GT, mvc_pkg::MODE_FLOOR_LT: begin
          a = small_q();
          b = 32'((int'($urandom_range(16)) - 8) * 65536);
        end
        mvc_pkg::MODE_DIFF_GT, mvc_pkg::MODE_DIFF_LT: a = 32'($urandom_range(32'h0004_0000));
        mvc_pkg::MODE_RANGE: begin
          a = small_q();
          b = a + 32'($urandom_range(32'h0008_0000));
          // An occasional empty range.
          if ($urandom_range(5) == 0) b = a - 32'h0001_0000;
        end
        default: ;
      endcase
    end
    apply_setting(mode, a, b);
  endtask

  // Samples are aimed at the edges of the active condition, with some noise mixed in.
  function automatic logic [31:0] next_sample(logic [3:0] ch);
    logic signed [31:0] a, b;
    int k;
    a = sb.ref_a;
    b = sb.ref_b;
    if ($urandom_range(4) == 0) return pick_word();
    case (sb.mode)
      mvc_pkg::MODE_MOD_EQ, mvc_pkg::MODE_MOD_GT, mvc_pkg::MODE_MOD_LT: begin
        k = int'($urandom_range(8));
        if ((b < 0) != (a < 0)) k = -k;
        return 32'(k * a + b);
      end
      mvc_pkg::MODE_FLOOR_EQ, mvc_pkg::MODE_FLOOR_GT, mvc_pkg::MODE_FLOOR_LT:
        return 32'((b >>> 16) * a + (($urandom_range(1) != 0) ? a / 2 : 0));
      mvc_pkg::MODE_DIFF_GT, mvc_pkg::MODE_DIFF_LT:
        return 32'(sb.prev_sample[ch] + (($urandom_range(1) != 0) ? a : -a)
                   + int'($urandom_range(2)) - 1);
      mvc_pkg::MODE_RANGE: begin
        case ($urandom_range(4))
          0: return 32'(a - 1);
          1: return a;
          2: return b;
          3: return 32'(b + 1);
          default: return 32'(a + int'($urandom_range(32'h0004_0000)));
        endcase
      end
      default: return 32'(a + int'($urandom_range(2)) - 1);
    endcase
  endfunction

  // Result side: random stalls, and every accepted word goes to the scoreboard.
  initial begin
    forever begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  initial begin
    logic [3:0] ch;
    logic [31:0] value;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    probe(mvc_pkg::MODE_NONE, 32'h0000_0000, 32'h0000_0000, 4'd0, 32'h8000_0000);
    probe(mvc_pkg::MODE_EQ, 32'h7fff_ffff, 32'h0000_0000, 4'd1, 32'h7fff_ffff);
    probe(mvc_pkg::MODE_NE, 32'h8000_0000, 32'h7fff_ffff, 4'd2, 32'h8000_0000);
    probe(mvc_pkg::MODE_GT, 32'h8000_0000, 32'h0000_0000, 4'd4, 32'h7fff_ffff);
    probe(mvc_pkg::MODE_LT, 32'h7fff_ffff, 32'h8000_0000, 4'd8, 32'h8000_0000);
    probe(mvc_pkg::MODE_GE, 32'h0000_0001, 32'h0000_0000, 4'd5, 32'h0000_0001);
    probe(mvc_pkg::MODE_LE, 32'hffff_ffff, 32'h0000_0000, 4'd10, 32'h0000_0000);
    // A zero divisor never matches.
    probe(mvc_pkg::MODE_MOD_EQ, 32'h0000_0000, 32'h0000_0000, 4'd0, 32'h0000_0005);
    probe(mvc_pkg::MODE_MOD_EQ, 32'hffff_ffff, 32'h0000_0000, 4'd0, 32'h8000_0000);
    // The remainder takes the sign of the dividend.
    probe(mvc_pkg::MODE_MOD_LT, 32'h0003_0000, 32'h0000_0000, 4'd0, 32'hfff9_0000);
    probe(mvc_pkg::MODE_MOD_GT, 32'h8000_0000, 32'h0000_0000, 4'd0, 32'h7fff_ffff);
    probe(mvc_pkg::MODE_FLOOR_EQ, 32'h0000_0000, 32'h0000_0000, 4'd0, 32'h0001_0000);
    // Quotients beyond the Q16.16 range saturate.
    probe(mvc_pkg::MODE_FLOOR_EQ, 32'hffff_ffff, 32'h7fff_ffff, 4'd0, 32'h8000_0000);
    probe(mvc_pkg::MODE_FLOOR_LT, 32'h0000_0002, 32'h0000_0000, 4'd0, 32'hffff_fffd);
    probe(mvc_pkg::MODE_FLOOR_GT, 32'h0000_0001, 32'h8000_0000, 4'd0, 32'h8000_0000);
    // Change magnitude needs the full 33 bits.
    probe(mvc_pkg::MODE_DIFF_GT, 32'h0000_0000, 32'h0000_0000, 4'd15, 32'h8000_0000);
    probe(mvc_pkg::MODE_DIFF_GT, 32'h7fff_ffff, 32'h0000_0000, 4'd15, 32'h7fff_ffff);
    probe(mvc_pkg::MODE_DIFF_LT, 32'h8000_0000, 32'h0000_0000, 4'd3, 32'h0000_0000);
    probe(mvc_pkg::MODE_DIFF_LT, 32'h0000_0001, 32'h0000_0000, 4'd3, 32'h0000_0000);
    // Lower bound above upper bound leaves the range empty.
    probe(mvc_pkg::MODE_RANGE, 32'h0000_0005, 32'h0000_0004, 4'd0, 32'h0000_0004);
    probe(mvc_pkg::MODE_RANGE, 32'h8000_0000, 32'h7fff_ffff, 4'd0, 32'h0000_0000);
    probe(mvc_pkg::MODE_RANGE, 32'hffff_ffff, 32'hffff_ffff, 4'd0, 32'hffff_ffff);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 82; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 82; end
        default: begin src_idle_pct = 38; sink_stall_pct = 38; end
      endcase
      for (int s = 0; s < ITEMS_PER_PHASE / ITEMS_PER_SETTING; s++) begin
        random_setting();
        repeat (ITEMS_PER_SETTING) begin
          ch = 4'($urandom_range(15));
          value = next_sample(ch);
          send_sample(ch, value);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_idle();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
